/* rtl/lpbs_pkg.sv */
// Shared types and constants for the linear-probe block set.
// No dependencies; imported by every module of the block.
package lpbs_pkg;

    localparam int DEF_TABLE_ENTRIES = 4096;
    localparam int KEY_W             = 64;
    localparam int ENTRY_W           = 12;

    // Fibonacci hashing multiplier (2^64 / golden ratio)
    localparam logic [KEY_W-1:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic REQ_QUERY  = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FINISH
    } lpbs_state_t;

endpackage

/* rtl/lpbs_table_ram.sv */
// Key table storage: one write port, one read port, registered read data.
// Depends on lpbs_pkg for the key width.
module lpbs_table_ram #(
    parameter int DEPTH = lpbs_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [lpbs_pkg::KEY_W-1:0]     wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [lpbs_pkg::KEY_W-1:0]     rd_data
);
    import lpbs_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/lpbs_hash.sv */
// Home-slot hash: low index bits of key times the golden-ratio constant.
// Depends on lpbs_pkg for the multiplier constant.
module lpbs_hash #(
    parameter int IDX_W = 12
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [IDX_W-1:0] key_lo,
    output logic [IDX_W-1:0] home_reg
);
    import lpbs_pkg::*;

    // Only the low bits of both factors reach the low bits of the product
    localparam logic [IDX_W-1:0] GOLD_LO = GOLDEN_MULT[IDX_W-1:0];

    logic [IDX_W-1:0] home_next;

    assign home_next = key_lo * GOLD_LO;

    always_ff @(posedge aclk) begin
        if (en) begin
            home_reg <= home_next;
        end
    end

endmodule

/* rtl/linear_probe_block_set_top.sv */
// Top level of the linear-probe block set: control sequencer around the key table.
// Depends on lpbs_pkg, lpbs_hash and lpbs_table_ram.
//
// Usage:
//   Input channel (s_valid/s_ready) carries a request: s_req_type selects query
//   or insert, s_block_key is the 64-bit block number. Result channel
//   (m_valid/m_ready) returns one transfer per request with found, inserted,
//   full_res and the key count after the request.
//   One request is worked on at a time. The probe reads one table slot per
//   cycle from the single table read port until it meets an empty slot or the
//   key; a key of zero skips the probe. Below half load the probe reads
//   about two slots on average. The result is registered and appears the cycle
//   after the request finishes.
//   Reset runs a clearing pass that writes zero to every slot, one slot per
//   cycle, with s_ready low until every slot is cleared.
//   A stalled receiver holds the result register; the next request is still
//   accepted, but its result waits until the previous one is transferred.
//   TABLE_ENTRIES must be a power of two; inserts stop at half load.
module linear_probe_block_set_top #(
    parameter int TABLE_ENTRIES = lpbs_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [lpbs_pkg::KEY_W-1:0]       s_block_key,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic                             m_inserted,
    output logic                             m_full_res,
    output logic [lpbs_pkg::ENTRY_W-1:0]     m_entry_count
);
    import lpbs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int HALF  = TABLE_ENTRIES / 2;
    localparam int CNT_W = $clog2(HALF + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = '1;
    localparam logic [CNT_W-1:0] CNT_HALF = CNT_W'(HALF);

    lpbs_state_t state_reg, state_next;

    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KEY_W-1:0]   key_reg;
    logic               req_reg;
    logic               zero_reg;

    logic               m_valid_reg, m_valid_next;
    logic               found_reg, found_next;
    logic               inserted_reg, inserted_next;
    logic               full_reg, full_next;
    logic [ENTRY_W-1:0] out_count_reg, out_count_next;

    logic               s_fire;
    logic               out_free;
    logic               new_insert;
    logic               do_store;
    logic               finish_fire;
    logic [IDX_W-1:0]   home_reg;

    logic               mem_wr_en;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [KEY_W-1:0]   mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_addr;
    logic [KEY_W-1:0]   mem_rd_data;

    lpbs_hash #(
        .IDX_W (IDX_W)
    ) u_hash (
        .aclk     (aclk),
        .en       (s_fire),
        .key_lo   (s_block_key[IDX_W-1:0]),
        .home_reg (home_reg)
    );

    lpbs_table_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign new_insert  = (req_reg == REQ_INSERT) && !hit_reg && !zero_reg;
    assign do_store    = new_insert && (count_reg < CNT_HALF);
    assign finish_fire = (state_reg == ST_FINISH) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        found_reg     <= found_next;
        inserted_reg  <= inserted_next;
        full_reg      <= full_next;
        out_count_reg <= out_count_next;
        if (s_fire) begin
            key_reg  <= s_block_key;
            req_reg  <= s_req_type;
            zero_reg <= (s_block_key == '0);
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        found_next     = found_reg;
        inserted_next  = inserted_reg;
        full_next      = full_reg;
        out_count_next = out_count_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = idx_reg;
        mem_wr_data    = key_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = idx_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == IDX_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    hit_next   = 1'b0;
                    // zero key is never stored: skip the probe
                    state_next = (s_block_key == '0) ? ST_FINISH : ST_HASH;
                end
            end
            ST_HASH: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = home_reg;
                idx_next    = home_reg;
                state_next  = ST_PROBE;
            end
            ST_PROBE: begin
                // idx_reg names the slot whose word is on mem_rd_data
                if (mem_rd_data == '0) begin
                    hit_next   = 1'b0;
                    state_next = ST_FINISH;
                end else if (mem_rd_data == key_reg) begin
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    mem_wr_en = do_store;
                    if (do_store) begin
                        count_next = count_reg + 1'b1;
                    end
                    found_next     = hit_reg;
                    inserted_next  = do_store;
                    full_next      = new_insert && !do_store;
                    out_count_next = ENTRY_W'(count_next);
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_inserted    = inserted_reg;
    assign m_full_res    = full_reg;
    assign m_entry_count = out_count_reg;

    // Occupancy never passes half the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_HALF)
        else $error("stored key count above half the table");

    // Outside the clearing pass only nonzero keys are written
    a_no_zero_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && state_reg != ST_CLEAR) |-> (mem_wr_data != '0))
        else $error("zero key written to table");

    // A result flags at most one of found, inserted and full
    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0({found_reg, inserted_reg, full_reg}))
        else $error("conflicting result flags");

    // A store bumps the count by exactly one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish_fire && do_store) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not advance on store");

endmodule
